// ===== rtl/core/bsfr_pkg.sv =====
// Shared constants, codes and types of the byte-stuffed frame receiver.
package bsfr_pkg;

    // Frame body size limit and the widths that follow from it.
    localparam int MAX_BODY_BYTES = 64;
    localparam int COUNT_W        = $clog2(MAX_BODY_BYTES + 1);
    localparam int INDEX_W        = 6;
    localparam int LENGTH_W       = 7;

    // Result queue geometry.
    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int FCNT_W     = $clog2(FIFO_DEPTH + 1);

    // Line codes.
    localparam logic [7:0] FLAG_BYTE  = 8'h7E;
    localparam logic [7:0] ESC_BYTE   = 8'h7D;
    localparam logic [7:0] ESC_FLAG   = 8'h5E;
    localparam logic [7:0] ESC_ESC    = 8'h5D;
    localparam logic [7:0] ESC_XON    = 8'h31;
    localparam logic [7:0] ESC_XOFF   = 8'h33;
    localparam logic [7:0] XON_BYTE   = 8'h11;
    localparam logic [7:0] XOFF_BYTE  = 8'h13;
    localparam logic [7:0] SUM_GOOD   = 8'hFF;

    typedef enum logic {
        KIND_DATA = 1'b0,
        KIND_END  = 1'b1
    } kind_t;

    typedef struct packed {
        kind_t               kind;
        logic [7:0]          payload;
        logic [INDEX_W-1:0]  index;
        logic [LENGTH_W-1:0] length;
        logic                sum_ok;
        logic                overflowed;
        logic                is_last;
    } result_t;

    typedef struct packed {
        logic               in_frame;
        logic               escape_pending;
        logic [COUNT_W-1:0] count;
        logic [7:0]         sum;
        logic               overflow_seen;
    } frame_state_t;

endpackage

// ===== rtl/core/bsfr_decode.sv =====
// Per-byte deframing and unstuffing logic: next frame state and up to two results.
module bsfr_decode
(
    input  bsfr_pkg::frame_state_t cur,
    input  logic [7:0]             rx_byte,
    output bsfr_pkg::frame_state_t nxt,
    output bsfr_pkg::result_t      res0,
    output bsfr_pkg::result_t      res1,
    output logic [1:0]             res_count
);

    logic                         first_en;
    logic                         second_en;
    logic                         close_en;
    logic                         esc_next;
    logic                         open_en;
    logic [7:0]                   first_b;
    logic                         first_ok;
    logic                         second_ok;
    logic [bsfr_pkg::COUNT_W-1:0] count1;
    logic [bsfr_pkg::COUNT_W-1:0] count2;
    logic [7:0]                   sum1;
    logic [7:0]                   sum2;
    logic                         ov1;
    logic                         ov2;
    bsfr_pkg::result_t            res_a;
    bsfr_pkg::result_t            res_b;

    // Classify the byte against the current framing state.
    always_comb
    begin
        first_en  = 1'b0;
        second_en = 1'b0;
        close_en  = 1'b0;
        esc_next  = 1'b0;
        open_en   = 1'b0;
        first_b   = rx_byte;
        if (!cur.in_frame)
        begin
            open_en = (rx_byte == bsfr_pkg::FLAG_BYTE);
        end
        else if (cur.escape_pending)
        begin
            first_en = 1'b1;
            unique case (rx_byte)
                bsfr_pkg::ESC_FLAG: first_b = bsfr_pkg::FLAG_BYTE;
                bsfr_pkg::ESC_ESC:  first_b = bsfr_pkg::ESC_BYTE;
                bsfr_pkg::ESC_XON:  first_b = bsfr_pkg::XON_BYTE;
                bsfr_pkg::ESC_XOFF: first_b = bsfr_pkg::XOFF_BYTE;
                default:
                begin
                    // Unknown escape: keep the escape byte, then treat this byte normally.
                    first_b   = bsfr_pkg::ESC_BYTE;
                    close_en  = (rx_byte == bsfr_pkg::FLAG_BYTE);
                    esc_next  = (rx_byte == bsfr_pkg::ESC_BYTE);
                    second_en = !close_en && !esc_next;
                end
            endcase
        end
        else if (rx_byte == bsfr_pkg::ESC_BYTE)
        begin
            esc_next = 1'b1;
        end
        else if (rx_byte == bsfr_pkg::FLAG_BYTE)
        begin
            close_en = 1'b1;
        end
        else
        begin
            first_en = 1'b1;
        end
    end

    // Two chained keep steps; each drops its byte once the body is full.
    always_comb
    begin
        first_ok  = first_en && (cur.count < bsfr_pkg::COUNT_W'(bsfr_pkg::MAX_BODY_BYTES));
        count1    = first_ok ? cur.count + bsfr_pkg::COUNT_W'(1) : cur.count;
        sum1      = first_ok ? cur.sum + first_b : cur.sum;
        ov1       = cur.overflow_seen || (first_en && !first_ok);

        second_ok = second_en && (count1 < bsfr_pkg::COUNT_W'(bsfr_pkg::MAX_BODY_BYTES));
        count2    = second_ok ? count1 + bsfr_pkg::COUNT_W'(1) : count1;
        sum2      = second_ok ? sum1 + rx_byte : sum1;
        ov2       = ov1 || (second_en && !second_ok);
    end

    always_comb
    begin
        res_a            = '0;
        res_a.kind       = bsfr_pkg::KIND_DATA;
        res_a.payload    = first_b;
        res_a.index      = bsfr_pkg::INDEX_W'(cur.count);

        res_b            = '0;
        if (close_en)
        begin
            res_b.kind       = bsfr_pkg::KIND_END;
            res_b.length     = bsfr_pkg::LENGTH_W'(count1);
            res_b.sum_ok     = (sum1 == bsfr_pkg::SUM_GOOD) && !ov1;
            res_b.overflowed = ov1;
        end
        else
        begin
            res_b.kind    = bsfr_pkg::KIND_DATA;
            res_b.payload = rx_byte;
            res_b.index   = bsfr_pkg::INDEX_W'(count1);
        end

        // Pack the results that were produced into the low slots, in order.
        res0         = first_ok ? res_a : res_b;
        res1         = res_b;
        res0.is_last = !(first_ok && (close_en || second_ok));
        res1.is_last = 1'b1;
        res_count    = {1'b0, first_ok} + {1'b0, close_en || second_ok};
    end

    always_comb
    begin
        nxt = cur;
        if (open_en)
        begin
            nxt = '0;
            nxt.in_frame = 1'b1;
        end
        else if (cur.in_frame)
        begin
            nxt.in_frame       = !close_en;
            nxt.escape_pending = esc_next;
            nxt.count          = count2;
            nxt.sum            = sum2;
            nxt.overflow_seen  = ov2;
        end
    end

endmodule

// ===== rtl/core/bsfr_result_fifo.sv =====
// Small result queue that takes up to two results a cycle and hands out one per beat.
module bsfr_result_fifo
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic [1:0]          push_count,
    input  bsfr_pkg::result_t   push0,
    input  bsfr_pkg::result_t   push1,
    input  logic                pop,
    output bsfr_pkg::result_t   head,
    output logic                not_empty,
    output logic                almost_full
);

    bsfr_pkg::result_t           entry_reg [bsfr_pkg::FIFO_DEPTH];
    logic [bsfr_pkg::PTR_W-1:0]  wr_ptr_reg;
    logic [bsfr_pkg::PTR_W-1:0]  wr_ptr_next;
    logic [bsfr_pkg::PTR_W-1:0]  rd_ptr_reg;
    logic [bsfr_pkg::PTR_W-1:0]  rd_ptr_next;
    logic [bsfr_pkg::FCNT_W-1:0] count_reg;
    logic [bsfr_pkg::FCNT_W-1:0] count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + bsfr_pkg::PTR_W'(push_count);
        rd_ptr_next = pop ? rd_ptr_reg + bsfr_pkg::PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + bsfr_pkg::FCNT_W'(push_count)
                      - bsfr_pkg::FCNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_count != 2'd0)
        begin
            entry_reg[wr_ptr_reg] <= push0;
        end
        if (push_count == 2'd2)
        begin
            entry_reg[wr_ptr_reg + bsfr_pkg::PTR_W'(1)] <= push1;
        end
    end

    assign head        = entry_reg[rd_ptr_reg];
    assign not_empty   = (count_reg != '0);
    assign almost_full = (count_reg > bsfr_pkg::FCNT_W'(bsfr_pkg::FIFO_DEPTH - 2));

    a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= bsfr_pkg::FCNT_W'(bsfr_pkg::FIFO_DEPTH))
        else $error("result queue count out of range");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> not_empty)
        else $error("result queue popped while empty");

    a_push_fits: assert property (@(posedge clk) disable iff (!rst_n)
        (push_count != 2'd0) |-> (!almost_full && push_count != 2'd3))
        else $error("result queue pushed without room");

endmodule

// ===== rtl/core/byte_stuffed_frame_receiver.sv =====
// Top level of the byte-stuffed frame receiver: framing state, decoder and result queue.
//
// Usage: raw serial bytes enter on the byte channel (byte_valid, byte_stall,
// rx_byte). Outside a frame every byte but the 0x7E flag is discarded; inside a
// frame the escape sequences are undone and each body byte leaves on the result
// channel (result_valid, result_stall and the result fields) with its index.
// The closing flag produces an end beat with the frame length, the sum check
// and the overflow flag. One input byte yields zero, one or two result beats,
// and is_last marks the final beat of each byte.
//
// A result enters the result queue when its byte is accepted and is shown once
// the results ahead of it have left. Bytes enter one per cycle while byte_stall
// is low, and results leave one beat per cycle while result_stall is low.
// The decoder sits directly in front of a four-entry result queue. byte_stall
// rises when three or more results are waiting, so the block keeps accepting
// bytes while the receiver holds a result, until three results are waiting.
// Body bytes past the size limit are dropped and reported as overflow.
// Reset (rst_n low, asynchronous) returns the block to flag hunting and empties
// the queue.
module byte_stuffed_frame_receiver
(
    input  logic       clk,
    input  logic       rst_n,

    input  logic       byte_valid,
    output logic       byte_stall,
    input  logic [7:0] rx_byte,

    output logic       result_valid,
    input  logic       result_stall,
    output logic       item_kind,
    output logic [7:0] payload_byte,
    output logic [5:0] byte_index,
    output logic [6:0] frame_length,
    output logic       sum_ok,
    output logic       overflowed,
    output logic       is_last
);

    bsfr_pkg::frame_state_t state_reg;
    bsfr_pkg::frame_state_t state_next;
    bsfr_pkg::result_t      res0;
    bsfr_pkg::result_t      res1;
    bsfr_pkg::result_t      head;
    logic [1:0]             res_count;
    logic [1:0]             push_count;
    logic                   byte_accept;
    logic                   result_pop;
    logic                   queue_not_empty;
    logic                   queue_almost_full;

    assign byte_accept = byte_valid && !byte_stall;
    assign result_pop  = result_valid && !result_stall;
    assign push_count  = byte_accept ? res_count : 2'd0;

    bsfr_decode u_decode
    (
        .cur       (state_reg),
        .rx_byte   (rx_byte),
        .nxt       (state_next),
        .res0      (res0),
        .res1      (res1),
        .res_count (res_count)
    );

    // The framing state only advances on an accepted byte.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else if (byte_accept)
        begin
            state_reg <= state_next;
        end
    end

    bsfr_result_fifo u_result_fifo
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .push_count  (push_count),
        .push0       (res0),
        .push1       (res1),
        .pop         (result_pop),
        .head        (head),
        .not_empty   (queue_not_empty),
        .almost_full (queue_almost_full)
    );

    assign byte_stall   = queue_almost_full;
    assign result_valid = queue_not_empty;
    assign item_kind    = logic'(head.kind);
    assign payload_byte = head.payload;
    assign byte_index   = head.index;
    assign frame_length = head.length;
    assign sum_ok       = head.sum_ok;
    assign overflowed   = head.overflowed;
    assign is_last      = head.is_last;

    // An end beat is always the final result of its byte.
    a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && item_kind) |-> is_last)
        else $error("end of frame beat not marked last");

endmodule

// ===== tb/byte_stuffed_frame_receiver_test.sv =====
// Self-checking testbench of the byte-stuffed frame receiver with its result scoreboard.
`timescale 1ns / 100ps

// The scoreboard mirrors the deframer state. It turns every accepted input beat into the
// result beats it should cause and matches them in order against the result channel.
class frame_scoreboard;
    bit                   in_frame;
    bit                   escape_pending;
    int unsigned          body_count;
    logic [7:0]           body_sum;
    bit                   overflow_seen;
    bsfr_pkg::result_t    step_beats[$];
    bsfr_pkg::result_t    expected_beats[$];
    int unsigned          failures;

    function new();
        in_frame       = 1'b0;
        escape_pending = 1'b0;
        body_count     = 0;
        body_sum       = 8'h00;
        overflow_seen  = 1'b0;
        failures       = 0;
    endfunction

    // A body byte past the size limit is dropped and only marks the frame as overflowed.
    function void keep_body_byte(logic [7:0] value);
        bsfr_pkg::result_t beat;
        if (body_count >= bsfr_pkg::MAX_BODY_BYTES)
        begin
            overflow_seen = 1'b1;
            return;
        end
        beat         = '0;
        beat.kind    = bsfr_pkg::KIND_DATA;
        beat.payload = value;
        beat.index   = body_count[bsfr_pkg::INDEX_W-1:0];
        step_beats.push_back(beat);
        body_sum   = body_sum + value;
        body_count = body_count + 1;
    endfunction

    function void close_frame_beat();
        bsfr_pkg::result_t beat;
        beat            = '0;
        beat.kind       = bsfr_pkg::KIND_END;
        beat.length     = body_count[bsfr_pkg::LENGTH_W-1:0];
        beat.sum_ok     = (body_sum == bsfr_pkg::SUM_GOOD) && !overflow_seen;
        beat.overflowed = overflow_seen;
        step_beats.push_back(beat);
        in_frame       = 1'b0;
        escape_pending = 1'b0;
    endfunction

    function void note_input(logic [7:0] rx);
        step_beats.delete();
        if (!in_frame)
        begin
            if (rx == bsfr_pkg::FLAG_BYTE)
            begin
                in_frame       = 1'b1;
                escape_pending = 1'b0;
                body_count     = 0;
                body_sum       = 8'h00;
                overflow_seen  = 1'b0;
            end
            return;
        end
        if (escape_pending)
        begin
            escape_pending = 1'b0;
            case (rx)
                bsfr_pkg::ESC_FLAG: keep_body_byte(bsfr_pkg::FLAG_BYTE);
                bsfr_pkg::ESC_ESC:  keep_body_byte(bsfr_pkg::ESC_BYTE);
                bsfr_pkg::ESC_XON:  keep_body_byte(bsfr_pkg::XON_BYTE);
                bsfr_pkg::ESC_XOFF: keep_body_byte(bsfr_pkg::XOFF_BYTE);
                default:
                begin
                    // Not a known escape code: the escape byte itself is kept and the
                    // second byte is treated as if no escape had come before it.
                    keep_body_byte(bsfr_pkg::ESC_BYTE);
                    if (rx == bsfr_pkg::FLAG_BYTE)
                        close_frame_beat();
                    else if (rx == bsfr_pkg::ESC_BYTE)
                        escape_pending = 1'b1;
                    else
                        keep_body_byte(rx);
                end
            endcase
        end
        else if (rx == bsfr_pkg::ESC_BYTE)
            escape_pending = 1'b1;
        else if (rx == bsfr_pkg::FLAG_BYTE)
            close_frame_beat();
        else
            keep_body_byte(rx);
        if (step_beats.size() > 0)
            step_beats[step_beats.size()-1].is_last = 1'b1;
        foreach (step_beats[i])
            expected_beats.push_back(step_beats[i]);
    endfunction

    function void compare_field(string name, logic [7:0] expected, logic [7:0] actual);
        if (actual !== expected)
        begin
            $error("%s mismatch: expected %0h, actual %0h", name, expected, actual);
            failures = failures + 1;
        end
    endfunction

    function void check_result(bsfr_pkg::result_t got);
        bsfr_pkg::result_t want;
        if (expected_beats.size() == 0)
        begin
            $error("unexpected result beat: kind %0h payload %0h index %0h length %0h",
                   got.kind, got.payload, got.index, got.length);
            failures = failures + 1;
            return;
        end
        want = expected_beats.pop_front();
        compare_field("item_kind",    8'(want.kind),       8'(got.kind));
        compare_field("payload_byte", want.payload,        got.payload);
        compare_field("byte_index",   8'(want.index),      8'(got.index));
        compare_field("frame_length", 8'(want.length),     8'(got.length));
        compare_field("sum_ok",       8'(want.sum_ok),     8'(got.sum_ok));
        compare_field("overflowed",   8'(want.overflowed), 8'(got.overflowed));
        compare_field("is_last",      8'(want.is_last),    8'(got.is_last));
    endfunction
endclass

module byte_stuffed_frame_receiver_test;

    // The run is cut off here. A correct run needs only a small fraction of it, even with
    // every byte causing two results, each result beat stalled hard, and long sender gaps.
    localparam int unsigned CYCLE_LIMIT   = 400000;
    // Number of in-frame bytes after which the random part stops opening new frames.
    localparam int unsigned RANDOM_BYTES  = 700;
    localparam int          DIRECTED_LEN  = 24;
    // Cycles of quiet after the last expected beat, during which any stray result beat
    // would still be seen and reported.
    localparam int          DRAIN_CYCLES  = 8;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_PERIODIC
    } stall_mode_t;

    logic       clk          = 1'b0;
    logic       rst_n        = 1'b0;
    logic       byte_valid   = 1'b0;
    logic       byte_stall;
    logic [7:0] rx_byte      = 8'h00;
    logic       result_valid;
    logic       result_stall = 1'b0;
    logic       item_kind;
    logic [7:0] payload_byte;
    logic [5:0] byte_index;
    logic [6:0] frame_length;
    logic       sum_ok;
    logic       overflowed;
    logic       is_last;

    frame_scoreboard   sb;
    int unsigned       cycle_count = 0;
    int unsigned       frame_bytes_sent = 0;
    int unsigned       burst_left = 0;
    stall_mode_t       stall_mode = STALL_NONE;
    int unsigned       stall_left = 0;
    logic [7:0]        directed_bytes [0:DIRECTED_LEN-1];

    byte_stuffed_frame_receiver i_dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_valid   (byte_valid),
        .byte_stall   (byte_stall),
        .rx_byte      (rx_byte),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .item_kind    (item_kind),
        .payload_byte (payload_byte),
        .byte_index   (byte_index),
        .frame_length (frame_length),
        .sum_ok       (sum_ok),
        .overflowed   (overflowed),
        .is_last      (is_last)
    );

    always #4 clk = ~clk;

    // Watchdog: a run that hangs is reported as failed.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // Both channels are sampled at the rising edge, where the values seen are the ones
    // that were stable before it. The input beat is noted before the result is checked,
    // although a result can only come from a byte accepted at an earlier edge.
    always @(posedge clk)
    begin
        bsfr_pkg::result_t got;
        if (rst_n)
        begin
            if (byte_valid && !byte_stall)
                sb.note_input(rx_byte);
            if (result_valid && !result_stall)
            begin
                got            = '0;
                got.kind       = bsfr_pkg::kind_t'(item_kind);
                got.payload    = payload_byte;
                got.index      = byte_index;
                got.length     = frame_length;
                got.sum_ok     = sum_ok;
                got.overflowed = overflowed;
                got.is_last    = is_last;
                sb.check_result(got);
            end
        end
    end

    // The receiver switches between stall behaviors at random intervals: no stall at
    // all, occasional stalls, mostly stalled, and a fixed on/off rhythm. The heavy mode
    // fills the result queue so that byte_stall gets exercised.
    always @(posedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode <= stall_mode_t'($urandom_range(0, 3));
            stall_left <= $urandom_range(20, 120);
        end
        else
            stall_left <= stall_left - 1;
        case (stall_mode)
            STALL_NONE:  result_stall <= 1'b0;
            STALL_LIGHT: result_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY: result_stall <= ($urandom_range(0, 3) != 0);
            default:     result_stall <= cycle_count[2];
        endcase
    end

    // Presents one byte and returns at the edge that accepts it. The sender works in
    // bursts; between bursts valid may drop for a random number of cycles. Once a burst is
    // running, valid stays high from one beat to the next.
    task automatic send_byte(logic [7:0] value);
        int unsigned gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            // Now and then a long burst gives a stretch with no sender idling at all.
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 150)
                                                     : $urandom_range(1, 20);
            if (gap > 0)
            begin
                byte_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left = burst_left - 1;
        byte_valid <= 1'b1;
        rx_byte    <= value;
        do
            @(posedge clk);
        while (byte_stall);
    endtask

    // Bytes that belong to a frame count toward the length of the random part; hunting
    // noise does not.
    task automatic frame_byte(logic [7:0] value);
        frame_bytes_sent = frame_bytes_sent + 1;
        send_byte(value);
    endtask

    // Sends one decoded body byte, stuffing it where the line code requires an escape.
    task automatic send_plain(logic [7:0] value);
        case (value)
            bsfr_pkg::FLAG_BYTE:
            begin
                frame_byte(bsfr_pkg::ESC_BYTE);
                frame_byte(bsfr_pkg::ESC_FLAG);
            end
            bsfr_pkg::ESC_BYTE:
            begin
                frame_byte(bsfr_pkg::ESC_BYTE);
                frame_byte(bsfr_pkg::ESC_ESC);
            end
            bsfr_pkg::XON_BYTE:
            begin
                frame_byte(bsfr_pkg::ESC_BYTE);
                frame_byte(bsfr_pkg::ESC_XON);
            end
            bsfr_pkg::XOFF_BYTE:
            begin
                frame_byte(bsfr_pkg::ESC_BYTE);
                frame_byte(bsfr_pkg::ESC_XOFF);
            end
            default: frame_byte(value);
        endcase
    endtask

    // One random frame. Most content is well formed with random values and a fair share
    // of the bytes that need stuffing; a few bytes are unknown escapes or raw noise that
    // may close the frame early. An oversize frame is drawn near or past the body size limit.
    task automatic send_frame(bit oversize);
        int unsigned body_len;
        int unsigned pick;
        logic [7:0]  value;
        logic [7:0]  sum;
        bit          sum_known;
        sum       = 8'h00;
        sum_known = 1'b1;
        // Garbage while hunting is ignored by the block.
        if ($urandom_range(0, 3) == 0)
        begin
            repeat ($urandom_range(1, 4))
            begin
                value = 8'($urandom);
                if (value == bsfr_pkg::FLAG_BYTE)
                    value = value ^ 8'h01;
                send_byte(value);
            end
        end
        frame_byte(bsfr_pkg::FLAG_BYTE);
        body_len = oversize ? $urandom_range(60, 72) : $urandom_range(0, 12);
        repeat (body_len)
        begin
            pick = $urandom_range(0, 19);
            if (pick < 2)
            begin
                // Escape followed by a byte that is not an escape code and not a framing
                // byte: both bytes land in the body.
                do
                    value = 8'($urandom);
                while (value == bsfr_pkg::ESC_FLAG || value == bsfr_pkg::ESC_ESC ||
                       value == bsfr_pkg::ESC_XON || value == bsfr_pkg::ESC_XOFF ||
                       value == bsfr_pkg::FLAG_BYTE || value == bsfr_pkg::ESC_BYTE);
                frame_byte(bsfr_pkg::ESC_BYTE);
                frame_byte(value);
                sum = sum + bsfr_pkg::ESC_BYTE + value;
            end
            else if (pick < 3)
            begin
                frame_byte(8'($urandom));
                sum_known = 1'b0;
            end
            else
            begin
                if (pick < 7)
                begin
                    case ($urandom_range(0, 3))
                        0:       value = bsfr_pkg::FLAG_BYTE;
                        1:       value = bsfr_pkg::ESC_BYTE;
                        2:       value = bsfr_pkg::XON_BYTE;
                        default: value = bsfr_pkg::XOFF_BYTE;
                    endcase
                end
                else
                    value = 8'($urandom);
                send_plain(value);
                sum = sum + value;
            end
        end
        // Often the last body byte is chosen so that the frame check passes.
        if (sum_known && !oversize && $urandom_range(0, 4) < 2)
            send_plain(bsfr_pkg::SUM_GOOD - sum);
        pick = $urandom_range(0, 9);
        if (pick == 0)
        begin
            // A dangling escape right before the closing flag.
            frame_byte(bsfr_pkg::ESC_BYTE);
            frame_byte(bsfr_pkg::FLAG_BYTE);
        end
        else if (pick != 1)
            frame_byte(bsfr_pkg::FLAG_BYTE);
        // Otherwise the frame is left open and the next opening flag closes it instead.
    endtask

    initial
    begin
        sb = new();
        // Directed bytes: noise while hunting, an empty frame, a one-byte frame whose sum
        // is good, then every escape code, an unknown escape, an escape followed by a
        // second escape, and an escape right before the closing flag.
        directed_bytes = '{8'h00, 8'hFF, bsfr_pkg::ESC_BYTE,
                           bsfr_pkg::FLAG_BYTE, bsfr_pkg::FLAG_BYTE,
                           bsfr_pkg::FLAG_BYTE, 8'hFF, bsfr_pkg::FLAG_BYTE,
                           bsfr_pkg::FLAG_BYTE,
                           bsfr_pkg::ESC_BYTE, bsfr_pkg::ESC_FLAG,
                           bsfr_pkg::ESC_BYTE, bsfr_pkg::ESC_ESC,
                           bsfr_pkg::ESC_BYTE, bsfr_pkg::ESC_XON,
                           bsfr_pkg::ESC_BYTE, bsfr_pkg::ESC_XOFF,
                           bsfr_pkg::ESC_BYTE, 8'h00,
                           bsfr_pkg::ESC_BYTE, bsfr_pkg::ESC_BYTE, bsfr_pkg::ESC_FLAG,
                           bsfr_pkg::ESC_BYTE, bsfr_pkg::FLAG_BYTE};

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_bytes[i])
            frame_byte(directed_bytes[i]);

        // The first random frame is oversize so the size limit is hit early; later ones
        // are oversize only now and then, since each one costs about seventy bytes.
        send_frame(1'b1);
        while (frame_bytes_sent < RANDOM_BYTES + DIRECTED_LEN)
            send_frame($urandom_range(0, 24) == 0);
        byte_valid <= 1'b0;

        while (sb.expected_beats.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.failures == 0 && sb.expected_beats.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule

// ===== sim.f =====
rtl/core/bsfr_pkg.sv
rtl/core/bsfr_decode.sv
rtl/core/bsfr_result_fifo.sv
rtl/core/byte_stuffed_frame_receiver.sv
tb/byte_stuffed_frame_receiver_test.sv
